// ===== src/cag_pkg.sv =====
// ----------------------------------------------------------------------------
// cag_pkg
// Shared constants and types of the cave automaton generation unit.
// ----------------------------------------------------------------------------
package cag_pkg;

  // Storage dimensions of the cave grid.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // Row and column address widths and widths of counters that can hold the full size.
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  // Configuration register map.
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BIRTH  = 2'd2;
  localparam logic [1:0] REG_DEATH  = 2'd3;

  // Command codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_GEN   = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       cell_in;
  } cag_in_t;

  typedef struct packed {
    logic cell_out;
    logic any_changed;
  } cag_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_G_CUR,
    S_G_RD,
    S_G_NEXT,
    S_G_COL,
    S_G_WB,
    S_DONE
  } cag_state_t;

endpackage

// ===== src/cave_automaton_generation_unit.sv =====
// ----------------------------------------------------------------------------
// cave_automaton_generation_unit
// Cave grid store with cell write, cell read and one-generation commands.
// ----------------------------------------------------------------------------
// How the block is used:
// Each input transaction on the in_ channel carries one command: write a cell,
// read a cell, or run one generation of the cave automaton. Every command
// returns exactly one result transaction on the out_ channel; cell_out holds
// the value for a read and any_changed tells whether a generation altered the
// grid. Commands are handled one at a time.
// A read or write ends in S_DONE, which loads the result; the next command is
// taken in the cycle after the one that loads the result.
// A generation fetches each active row through the single read port of the
// row memory and sweeps the active columns of that row one cell per cycle.
// The grid lives in a memory of one 64-bit word per row. Reset clears one valid
// flag per row, so a row never written reads as all zero; no clearing pass is
// needed. Reset also loads the configuration defaults (50, 50, 4, 3).
// A finished result sits in an output register. A new command is accepted
// while that result waits; if the receiver still stalls when the next result
// is ready, the block holds that result and takes no further command.
// Configuration is to be written by the user through the APB-style port while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cave_automaton_generation_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Command channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cag_pkg::cag_in_t               in_data,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output cag_pkg::cag_out_t              out_data,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cag_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cag_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0] grid_height_r;
  logic [6:0] grid_width_r;
  logic [3:0] birth_limit_r;
  logic [3:0] death_limit_r;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_height_r <= 7'd50;
      grid_width_r  <= 7'd50;
      birth_limit_r <= 4'd4;
      death_limit_r <= 4'd3;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_HEIGHT: grid_height_r <= pwdata[6:0];
        REG_WIDTH:  grid_width_r  <= pwdata[6:0];
        REG_BIRTH:  birth_limit_r <= pwdata[3:0];
        REG_DEATH:  death_limit_r <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEIGHT: prdata = {25'd0, grid_height_r};
      REG_WIDTH:  prdata = {25'd0, grid_width_r};
      REG_BIRTH:  prdata = {28'd0, birth_limit_r};
      REG_DEATH:  prdata = {28'd0, death_limit_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Active area, clipped to the storage size.
  logic [RCNT_W-1:0] h_eff;
  logic [CCNT_W-1:0] w_eff;

  assign h_eff = (32'(grid_height_r) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(grid_height_r);
  assign w_eff = (32'(grid_width_r) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(grid_width_r);

  // --------------------------------------------------------------------------
  // Row memory: one word per grid row, registered read, per-row valid flags
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] cell_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] mem_q_r;
  logic [MAX_ROWS-1:0] row_vld_r;
  logic                rd_vld_r;
  logic [ROW_AW-1:0]   rd_addr;
  logic                mem_we;
  logic [ROW_AW-1:0]   mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [MAX_COLS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[rd_addr];
      if (mem_we) begin
        row_vld_r[mem_waddr] <= 1'b1;
      end
    end
  end

  // A row that was never written reads as all empty.
  assign rd_data = rd_vld_r ? mem_q_r : '0;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  cag_state_t          state_r, state_nxt;
  cag_in_t             req_r, req_nxt;
  cag_out_t            res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  cag_out_t            out_data_r, out_data_nxt;
  logic [RCNT_W-1:0]   row_r, row_nxt;
  logic [CCNT_W-1:0]   col_r, col_nxt;
  logic [MAX_COLS-1:0] prev_r, prev_nxt;
  logic [MAX_COLS-1:0] cur_r, cur_nxt;
  logic [MAX_COLS-1:0] next_r, next_nxt;
  logic [MAX_COLS-1:0] new_row_r, new_row_nxt;
  logic                changed_r, changed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers need no reset.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    next_r     <= next_nxt;
    new_row_r  <= new_row_nxt;
    changed_r  <= changed_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Neighbour count of the cell at column col_r of row row_r. Positions left
  // of column 0 or right of the last active column count as alive; rows above
  // and below the active area were loaded as all alive.
  // --------------------------------------------------------------------------
  logic [CCNT_W-1:0] col_m1;
  logic [CCNT_W-1:0] col_p1;
  logic [COL_AW-1:0] c_idx;
  logic [COL_AW-1:0] l_idx;
  logic [COL_AW-1:0] r_idx;
  logic              left_in;
  logic              right_in;
  logic [7:0]        nbrs;
  logic [3:0]        nbr_cnt;
  logic              cell_old;
  logic              cell_new;

  assign col_m1   = col_r - CCNT_W'(1);
  assign col_p1   = col_r + CCNT_W'(1);
  assign c_idx    = col_r[COL_AW-1:0];
  assign l_idx    = col_m1[COL_AW-1:0];
  assign r_idx    = col_p1[COL_AW-1:0];
  assign left_in  = (col_r != '0);
  assign right_in = (col_p1 < w_eff);

  always_comb begin
    nbrs[0] = left_in  ? prev_r[l_idx] : 1'b1;
    nbrs[1] = prev_r[c_idx];
    nbrs[2] = right_in ? prev_r[r_idx] : 1'b1;
    nbrs[3] = left_in  ? cur_r[l_idx]  : 1'b1;
    nbrs[4] = right_in ? cur_r[r_idx]  : 1'b1;
    nbrs[5] = left_in  ? next_r[l_idx] : 1'b1;
    nbrs[6] = next_r[c_idx];
    nbrs[7] = right_in ? next_r[r_idx] : 1'b1;
  end

  assign nbr_cnt  = 4'($countones(nbrs));
  assign cell_old = cur_r[c_idx];

  always_comb begin
    cell_new = cell_old;
    if (!cell_old && (nbr_cnt > birth_limit_r)) begin
      cell_new = 1'b1;
    end else if (cell_old && (nbr_cnt < death_limit_r)) begin
      cell_new = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Command sequencer
  // --------------------------------------------------------------------------
  logic req_inside;
  logic in_inside;
  logic last_row;

  assign req_inside = (32'(req_r.row_index) < MAX_ROWS) && (32'(req_r.col_index) < MAX_COLS);
  assign in_inside  = (32'(in_data.row_index) < MAX_ROWS) &&
                      (32'(in_data.col_index) < MAX_COLS);
  assign last_row   = ((row_r + RCNT_W'(1)) == h_eff);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    new_row_nxt   = new_row_r;
    changed_nxt   = changed_r;
    rd_addr       = ROW_AW'(row_r + RCNT_W'(1));
    mem_we        = 1'b0;
    mem_waddr     = row_r[ROW_AW-1:0];
    mem_wdata     = new_row_r;

    // The result register is freed by the receiver.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_addr = ROW_AW'(in_data.row_index);
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          case (in_data.cmd)
            CMD_WRITE, CMD_READ: begin
              state_nxt = in_inside ? S_RMW : S_DONE;
            end
            CMD_GEN: begin
              if ((h_eff == '0) || (w_eff == '0)) begin
                state_nxt = S_DONE;
              end else begin
                rd_addr     = '0;
                row_nxt     = '0;
                prev_nxt    = '1;
                changed_nxt = 1'b0;
                state_nxt   = S_G_CUR;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Row word of the addressed cell is on rd_data.
      S_RMW: begin
        mem_waddr = ROW_AW'(req_r.row_index);
        mem_wdata = rd_data;
        mem_wdata[COL_AW'(req_r.col_index)] = req_r.cell_in;
        if (req_r.cmd == CMD_WRITE) begin
          mem_we = req_inside;
        end else begin
          res_nxt.cell_out = rd_data[COL_AW'(req_r.col_index)];
        end
        state_nxt = S_DONE;
      end

      // First row arrives; fetch the row below it.
      S_G_CUR: begin
        cur_nxt   = rd_data;
        state_nxt = S_G_NEXT;
      end

      S_G_RD: begin
        state_nxt = S_G_NEXT;
      end

      S_G_NEXT: begin
        next_nxt    = last_row ? '1 : rd_data;
        new_row_nxt = cur_r;
        col_nxt     = '0;
        state_nxt   = S_G_COL;
      end

      S_G_COL: begin
        new_row_nxt[c_idx] = cell_new;
        if (cell_new != cell_old) begin
          changed_nxt = 1'b1;
        end
        if (col_p1 == w_eff) begin
          state_nxt = S_G_WB;
        end else begin
          col_nxt = col_p1;
        end
      end

      // Old row r is kept in prev, so the new row can overwrite it in place.
      S_G_WB: begin
        mem_we   = 1'b1;
        prev_nxt = cur_r;
        cur_nxt  = next_r;
        row_nxt  = row_r + RCNT_W'(1);
        if (last_row) begin
          res_nxt.any_changed = changed_r;
          state_nxt           = S_DONE;
        end else begin
          state_nxt = S_G_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every accepted command leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted command did not start");

  // The generation sweep stays inside the active area.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_COL) |-> ((row_r < h_eff) && (col_r < w_eff)))
    else $error("generation sweep left the active area");

  // Memory writes happen only in the write-back states.
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_RMW) || (state_r == S_G_WB)))
    else $error("unexpected memory write");

  // A written row is marked valid on the next cycle.
  a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> row_vld_r[$past(mem_waddr)])
    else $error("written row not marked valid");

  // A result is loaded only when the output register is free or drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result overwritten while stalled");

endmodule
